>>> hw/rtl/gca_pkg.sv
// gca_pkg: shared types and constants for the great-circle arc intersection pipeline
// used by every module under hw/rtl, no dependencies
package gca_pkg;

	localparam int FRAC_BITS = 30;
	localparam int TOL_W     = 21;
	localparam logic [TOL_W-1:0] TOL_RESET = 21'd1074;

	typedef logic [2:0][31:0] v32x3_t;
	typedef logic [2:0][32:0] v33x3_t;
	typedef logic [2:0][36:0] v37x3_t;
	typedef logic [2:0][64:0] n65x3_t;

	typedef struct packed {
		logic signed [31:0] a_start_x;
		logic signed [31:0] a_start_y;
		logic signed [31:0] a_start_z;
		logic signed [31:0] a_end_x;
		logic signed [31:0] a_end_y;
		logic signed [31:0] a_end_z;
		logic signed [31:0] b_start_x;
		logic signed [31:0] b_start_y;
		logic signed [31:0] b_start_z;
		logic signed [31:0] b_end_x;
		logic signed [31:0] b_end_y;
		logic signed [31:0] b_end_z;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} out_t;

	// side data that rides along the parameter divider
	typedef struct packed {
		logic   vld;
		logic   ok;
		logic   over;
		v32x3_t st;
		v33x3_t d;
	} tlane_t;

	// side data that rides along the square root
	typedef struct packed {
		logic   vld;
		logic   hit;
		v37x3_t pa;
	} slane_t;

	// side data that rides along the normalize divider
	typedef struct packed {
		logic       vld;
		logic       hit;
		logic [2:0] neg;
	} nlane_t;

endpackage

>>> hw/rtl/gca_dot.sv
// gca_dot: triple products of one arc against the other arc's plane normal
// gives |numerator|, |denominator| of t and range flags, four stages; uses gca_pkg
module gca_dot (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld,
	input  gca_pkg::n65x3_t nrm,
	input  gca_pkg::v32x3_t st,
	input  gca_pkg::v33x3_t dir,
	output logic [99:0]     num,
	output logic [99:0]     den,
	output gca_pkg::tlane_t side
);
	import gca_pkg::*;

	logic signed [64:0] nl_s1 [3];
	logic signed [64:0] nh_s1 [3];
	logic signed [65:0] dl_s1 [3];
	logic signed [65:0] dh_s1 [3];
	v32x3_t st_s1, st_s2, st_s3, st_s4;
	v33x3_t d_s1, d_s2, d_s3, d_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [100:0] num_s2, den_s2;
	logic signed [100:0] nsum, dsum;
	logic [99:0] num_s3, den_s3, num_s4, den_s4;
	logic signed [100:0] nn, dd;
	logic ok_c, ok_s3, ok_s4, over_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// split the normal into a low unsigned half and a high signed half
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nl_s1[i] <= $signed({1'b0, nrm[i][31:0]}) * $signed(st[i]);
				nh_s1[i] <= $signed(nrm[i][64:32]) * $signed(st[i]);
				dl_s1[i] <= $signed({1'b0, nrm[i][31:0]}) * $signed(dir[i]);
				dh_s1[i] <= $signed(nrm[i][64:32]) * $signed(dir[i]);
			end
			st_s1 <= st;
			d_s1  <= dir;
		end
	end

	always_comb begin
		nsum = '0;
		dsum = '0;
		for (int i = 0; i < 3; i++) begin
			nsum = nsum + (101'(nh_s1[i]) <<< 32) + 101'(nl_s1[i]);
			dsum = dsum + (101'(dh_s1[i]) <<< 32) + 101'(dl_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= -nsum;
			den_s2 <= dsum;
			st_s2  <= st_s1;
			d_s2   <= d_s1;
		end
	end

	// fold the sign of the denominator into the numerator
	always_comb begin
		if (den_s2[100]) begin
			nn = -num_s2;
			dd = -den_s2;
		end else begin
			nn = num_s2;
			dd = den_s2;
		end
		ok_c = (dd != '0) && !nn[100] && (nn != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= nn[99:0];
			den_s3 <= dd[99:0];
			ok_s3  <= ok_c;
			st_s3  <= st_s2;
			d_s3   <= d_s2;
		end
	end

	// quotient would need more than 33 bits
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= num_s3;
			den_s4  <= den_s3;
			ok_s4   <= ok_s3;
			over_s4 <= {2'b00, num_s3} >= {den_s3, 2'b00};
			st_s4   <= st_s3;
			d_s4    <= d_s3;
		end
	end

	assign num       = num_s4;
	assign den       = den_s4;
	assign side.vld  = vld_s4;
	assign side.ok   = ok_s4;
	assign side.over = over_s4;
	assign side.st   = st_s4;
	assign side.d    = d_s4;

endmodule

>>> hw/rtl/gca_tdiv.sv
// gca_tdiv: pipelined restoring divider, floor(num * 2^31 / den), 33 quotient bits
// one quotient bit per stage, side data travels alongside; uses gca_pkg
module gca_tdiv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [99:0]     num,
	input  logic [99:0]     den,
	input  gca_pkg::tlane_t side_i,
	output logic [32:0]     quo,
	output logic            rnz,
	output gca_pkg::tlane_t side_o
);
	import gca_pkg::*;

	logic [99:0] rem_s [33];
	logic [99:0] den_s [33];
	logic [32:0] quo_s [33];
	tlane_t      side_s [33];
	logic        lsb_s0;

	for (genvar k = 0; k < 33; k++) begin : g_stg
		logic [100:0] r_in;
		logic [99:0]  dv;
		logic [32:0]  qv;
		tlane_t       sv;
		logic [101:0] diff;
		logic         ge;

		if (k == 0) begin : g_first
			// quotient bits above 32 are zero, so start from num / 2
			assign r_in = {2'b00, num[99:1]};
			assign dv   = den;
			assign qv   = '0;
			assign sv   = side_i;
			always_ff @(posedge clk) begin
				if (en) begin
					lsb_s0 <= num[0];
				end
			end
		end else begin : g_next
			assign r_in = {rem_s[k-1], (k == 1) ? lsb_s0 : 1'b0};
			assign dv   = den_s[k-1];
			assign qv   = quo_s[k-1];
			assign sv   = side_s[k-1];
		end

		assign diff = {1'b0, r_in} - {2'b00, dv};
		assign ge   = ~diff[101];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[99:0] : r_in[99:0];
				den_s[k] <= dv;
				quo_s[k] <= {qv[31:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= sv;
			end
		end
	end

	assign quo    = quo_s[32];
	assign rnz    = rem_s[32] != '0;
	assign side_o = side_s[32];

endmodule

>>> hw/rtl/gca_isqrt.sv
// gca_isqrt: pipelined integer square root of a 76 bit value, 38 result bits
// two radicand bits per stage; uses gca_pkg
module gca_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [75:0]     rad,
	input  gca_pkg::slane_t side_i,
	output logic [37:0]     root,
	output gca_pkg::slane_t side_o
);
	import gca_pkg::*;

	logic [39:0] rem_s  [38];
	logic [37:0] root_s [38];
	logic [75:0] rad_s  [38];
	slane_t      side_s [38];

	for (genvar j = 0; j < 38; j++) begin : g_stg
		logic [39:0] rp;
		logic [37:0] qp;
		logic [75:0] sp;
		slane_t      sv;
		logic [41:0] r2;
		logic [39:0] tr;
		logic [42:0] diff;
		logic        ge;

		if (j == 0) begin : g_first
			assign rp = '0;
			assign qp = '0;
			assign sp = rad;
			assign sv = side_i;
		end else begin : g_next
			assign rp = rem_s[j-1];
			assign qp = root_s[j-1];
			assign sp = rad_s[j-1];
			assign sv = side_s[j-1];
		end

		assign r2   = {rp, sp[75-2*j -: 2]};
		assign tr   = {qp, 2'b01};
		assign diff = {1'b0, r2} - {3'b000, tr};
		assign ge   = ~diff[42];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[39:0] : r2[39:0];
				root_s[j] <= {qp[36:0], ge};
				rad_s[j]  <= sp;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[j] <= '0;
			end else if (en) begin
				side_s[j] <= sv;
			end
		end
	end

	assign root   = root_s[37];
	assign side_o = side_s[37];

endmodule

>>> hw/rtl/gca_ndiv.sv
// gca_ndiv: three lane pipelined divider, floor(mag * 2^30 / len), 31 quotient bits
// magnitudes never exceed len, so the quotient stays at or below 2^30; uses gca_pkg
module gca_ndiv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [2:0][35:0] mag,
	input  logic [37:0]     len,
	input  gca_pkg::nlane_t side_i,
	output logic [2:0][30:0] quo,
	output gca_pkg::nlane_t side_o
);
	import gca_pkg::*;

	logic [2:0][37:0] rem_s [31];
	logic [2:0][30:0] quo_s [31];
	logic [37:0]      len_s [31];
	nlane_t           side_s [31];

	for (genvar k = 0; k < 31; k++) begin : g_stg
		logic [2:0][38:0] r_in;
		logic [2:0][39:0] diff;
		logic [2:0][30:0] qv;
		logic [37:0]      lv;
		nlane_t           sv;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign r_in[i] = {3'b000, mag[i]};
			end
			assign qv = '0;
			assign lv = len;
			assign sv = side_i;
		end else begin : g_next
			for (genvar i = 0; i < 3; i++) begin : g_ln
				assign r_in[i] = {rem_s[k-1][i], 1'b0};
			end
			assign qv = quo_s[k-1];
			assign lv = len_s[k-1];
			assign sv = side_s[k-1];
		end

		for (genvar i = 0; i < 3; i++) begin : g_sub
			assign diff[i] = {1'b0, r_in[i]} - {2'b00, lv};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][i] <= diff[i][39] ? r_in[i][37:0] : diff[i][37:0];
					quo_s[k][i] <= {qv[i][29:0], ~diff[i][39]};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k] <= lv;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= sv;
			end
		end
	end

	assign quo    = quo_s[30];
	assign side_o = side_s[30];

endmodule

>>> hw/rtl/great_circle_arc_intersect_unit.sv
// channel | valid     | stall     | payload
// arcs in | arc_valid | arc_stall | arcs (gca_pkg::in_t)
// result  | res_valid | res_stall | res  (gca_pkg::out_t)
// one arc pair enters per cycle while arc_stall is low; each pair passes through
// the 33 stage parameter divider, the 38 stage square root and the 31 stage
// normalize divider. arst_n clears all valid bits and loads tolerance with 1074.
// a stalled result freezes the whole pipeline, and arc_stall follows it in the same cycle.
// the user writes tolerance (tol_we, tol_wdata) only while the pipeline holds no item; not enforced by the unit.
module great_circle_arc_intersect_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     arc_valid,
	output logic                     arc_stall,
	input  gca_pkg::in_t             arcs,
	output logic                     res_valid,
	input  logic                     res_stall,
	output gca_pkg::out_t            res,
	input  logic                     tol_we,
	input  logic [gca_pkg::TOL_W-1:0] tol_wdata
);
	import gca_pkg::*;

	logic en;
	logic [TOL_W-1:0] tol_q;

	v32x3_t as_v, ae_v, bs_v, be_v;

	logic signed [63:0] cpa_s1 [6];
	logic signed [63:0] cpb_s1 [6];
	v32x3_t as_s1, bs_s1, as_s2, bs_s2;
	v33x3_t ad_s1, bd_s1, ad_s2, bd_s2;
	n65x3_t na_s2, nb_s2;
	logic v_s1, v_s2;

	logic [99:0] numa, dena, numb, denb;
	tlane_t dsa, dsb, tsa, tsb;
	logic [32:0] qa, qb;
	logic rnza, rnzb;

	logic [33:0] lim;
	logic fa, fb;

	logic signed [66:0] pra_p1 [3];
	logic signed [66:0] prb_p1 [3];
	v32x3_t sta_p1, stb_p1;
	logic v_p1, h_p1;

	v37x3_t pa_p2, pb_p2;
	logic v_p2, h_p2;

	logic signed [73:0] dq_m1 [3];
	logic signed [73:0] sq_m1 [3];
	v37x3_t pa_m1;
	logic v_m1, h_m1;

	logic signed [75:0] dpsum, sqsum;
	logic [75:0] s_m2;
	v37x3_t pa_m2;
	logic v_m2, h_m2;
	slane_t sl_m2, sl_o;
	logic [37:0] root;

	logic [2:0][35:0] mag_n0;
	logic [37:0] len_n0;
	logic [2:0] neg_n0;
	logic v_n0, h_n0;
	nlane_t nl_n0, nl_o;
	logic [2:0][30:0] nq;

	logic [2:0][31:0] pt;

	assign en        = !(res_valid && res_stall);
	assign arc_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	assign as_v = {arcs.a_start_z, arcs.a_start_y, arcs.a_start_x};
	assign ae_v = {arcs.a_end_z, arcs.a_end_y, arcs.a_end_x};
	assign bs_v = {arcs.b_start_z, arcs.b_start_y, arcs.b_start_x};
	assign be_v = {arcs.b_end_z, arcs.b_end_y, arcs.b_end_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_n0 <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= arc_valid;
			v_s2 <= v_s1;
			v_p1 <= tsa.vld;
			v_p2 <= v_p1;
			v_m1 <= v_p2;
			v_m2 <= v_m1;
			v_n0 <= sl_o.vld;
			res_valid <= nl_o.vld;
		end
	end

	// cross product terms: na = a_end x a_start, nb = b_end x b_start
	always_ff @(posedge clk) begin
		if (en) begin
			cpa_s1[0] <= $signed(ae_v[1]) * $signed(as_v[2]);
			cpa_s1[1] <= $signed(ae_v[2]) * $signed(as_v[1]);
			cpa_s1[2] <= $signed(ae_v[2]) * $signed(as_v[0]);
			cpa_s1[3] <= $signed(ae_v[0]) * $signed(as_v[2]);
			cpa_s1[4] <= $signed(ae_v[0]) * $signed(as_v[1]);
			cpa_s1[5] <= $signed(ae_v[1]) * $signed(as_v[0]);
			cpb_s1[0] <= $signed(be_v[1]) * $signed(bs_v[2]);
			cpb_s1[1] <= $signed(be_v[2]) * $signed(bs_v[1]);
			cpb_s1[2] <= $signed(be_v[2]) * $signed(bs_v[0]);
			cpb_s1[3] <= $signed(be_v[0]) * $signed(bs_v[2]);
			cpb_s1[4] <= $signed(be_v[0]) * $signed(bs_v[1]);
			cpb_s1[5] <= $signed(be_v[1]) * $signed(bs_v[0]);
			for (int i = 0; i < 3; i++) begin
				ad_s1[i] <= 33'($signed(ae_v[i])) - 33'($signed(as_v[i]));
				bd_s1[i] <= 33'($signed(be_v[i])) - 33'($signed(bs_v[i]));
			end
			as_s1 <= as_v;
			bs_s1 <= bs_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				na_s2[i] <= 65'(cpa_s1[2*i]) - 65'(cpa_s1[2*i+1]);
				nb_s2[i] <= 65'(cpb_s1[2*i]) - 65'(cpb_s1[2*i+1]);
			end
			as_s2 <= as_s1;
			bs_s2 <= bs_s1;
			ad_s2 <= ad_s1;
			bd_s2 <= bd_s1;
		end
	end

	gca_dot u_dot_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(v_s2),
		.nrm(nb_s2), .st(as_s2), .dir(ad_s2),
		.num(numa), .den(dena), .side(dsa)
	);

	gca_dot u_dot_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(v_s2),
		.nrm(na_s2), .st(bs_s2), .dir(bd_s2),
		.num(numb), .den(denb), .side(dsb)
	);

	gca_tdiv u_tdiv_a (
		.clk(clk), .arst_n(arst_n), .en(en), .num(numa), .den(dena),
		.side_i(dsa), .quo(qa), .rnz(rnza), .side_o(tsa)
	);

	gca_tdiv u_tdiv_b (
		.clk(clk), .arst_n(arst_n), .en(en), .num(numb), .den(denb),
		.side_i(dsb), .quo(qb), .rnz(rnzb), .side_o(tsb)
	);

	// t must lie above tol/2 and below 1 + tol, t scaled by 2^31
	always_comb begin
		lim = {3'b001, 31'b0} + {12'b0, tol_q, 1'b0};
		fa = tsa.ok && !tsa.over
			&& ((qa > {12'b0, tol_q}) || ((qa == {12'b0, tol_q}) && rnza))
			&& ({1'b0, qa} < lim);
		fb = tsb.ok && !tsb.over
			&& ((qb > {12'b0, tol_q}) || ((qb == {12'b0, tol_q}) && rnzb))
			&& ({1'b0, qb} < lim);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pra_p1[i] <= $signed(tsa.d[i]) * $signed({1'b0, qa});
				prb_p1[i] <= $signed(tsb.d[i]) * $signed({1'b0, qb});
			end
			sta_p1 <= tsa.st;
			stb_p1 <= tsb.st;
			h_p1   <= fa && fb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_p2[i] <= 37'($signed(sta_p1[i])) + 37'($signed(pra_p1[i][66:31]));
				pb_p2[i] <= 37'($signed(stb_p1[i])) + 37'($signed(prb_p1[i][66:31]));
			end
			h_p2 <= h_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dq_m1[i] <= $signed(pa_p2[i]) * $signed(pb_p2[i]);
				sq_m1[i] <= $signed(pa_p2[i]) * $signed(pa_p2[i]);
			end
			pa_m1 <= pa_p2;
			h_m1  <= h_p2;
		end
	end

	always_comb begin
		dpsum = 76'(dq_m1[0]) + 76'(dq_m1[1]) + 76'(dq_m1[2]);
		sqsum = 76'(sq_m1[0]) + 76'(sq_m1[1]) + 76'(sq_m1[2]);
	end

	// points must share a hemisphere
	always_ff @(posedge clk) begin
		if (en) begin
			s_m2  <= sqsum;
			pa_m2 <= pa_m1;
			h_m2  <= h_m1 && !dpsum[75] && (dpsum != '0);
		end
	end

	assign sl_m2 = {v_m2, h_m2, pa_m2};

	gca_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .rad(s_m2),
		.side_i(sl_m2), .root(root), .side_o(sl_o)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_n0[i] <= sl_o.pa[i][36];
				mag_n0[i] <= sl_o.pa[i][36] ? 36'(-$signed(sl_o.pa[i])) : sl_o.pa[i][35:0];
			end
			len_n0 <= root;
			h_n0   <= sl_o.hit && (root != '0);
		end
	end

	assign nl_n0 = {v_n0, h_n0, neg_n0};

	gca_ndiv u_ndiv (
		.clk(clk), .arst_n(arst_n), .en(en), .mag(mag_n0), .len(len_n0),
		.side_i(nl_n0), .quo(nq), .side_o(nl_o)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!nl_o.hit) begin
				pt[i] = '0;
			end else if (nl_o.neg[i]) begin
				pt[i] = -{1'b0, nq[i]};
			end else begin
				pt[i] = {1'b0, nq[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.hit     <= nl_o.hit;
			res.point_x <= pt[0];
			res.point_y <= pt[1];
			res.point_z <= pt[2];
		end
	end

endmodule

>>> hw/rtl/gca_chk.sv
// gca_chk: port level checks for great_circle_arc_intersect_unit
// bound to the top level below; uses gca_pkg
module gca_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      arc_stall,
	input logic                      res_valid,
	input logic                      res_stall,
	input gca_pkg::out_t             res
);
	import gca_pkg::*;

	// a held result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed under stall");

	// input side only backs up when a result is stuck
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		arc_stall == (res_valid && res_stall))
		else $error("arc_stall not tied to result stall");

	// a miss carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.point_x == 0 && res.point_y == 0 && res.point_z == 0)
		else $error("nonzero point on miss");

	// normalized components never exceed one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |->
			res.point_x <= 32'sd1073741824 && res.point_x >= -32'sd1073741824 &&
			res.point_y <= 32'sd1073741824 && res.point_y >= -32'sd1073741824 &&
			res.point_z <= 32'sd1073741824 && res.point_z >= -32'sd1073741824)
		else $error("point component above unit length");

endmodule

bind great_circle_arc_intersect_unit gca_chk u_gca_chk (.*);
